// ----- rtl/rxd_pkg.sv -----
// ----------------------------------------------------------------------------
// rxd_pkg
// Shared types and constants of the two-layer byte decryptor: request codes,
// register indexes and the control bundles between the sequencer and memories.
// ----------------------------------------------------------------------------
package rxd_pkg;

    // permutation table geometry
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;

    // seed held in four 64-bit words, at most 32 bytes
    localparam int SEED_MAX_BYTES = 32;
    localparam int SEED_IDX_W     = $clog2(SEED_MAX_BYTES);
    localparam int SEED_WORDS     = 4;
    localparam int WORD_W         = 64;

    // request kinds carried on the input tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MASK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CIPHER = 2'd2;

    // configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SEED0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEED1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEED2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEED3 = 2'd3;

    typedef logic [SEED_WORDS-1:0][WORD_W-1:0] seed_t;

    // access bundle for the permutation table
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [TBL_AW-1:0] rd_addr;
    } tbl_req_t;

    // control bundle for the mask store
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } mask_ctl_t;

endpackage

// ----- rtl/rc4_with_xor_mask_decryptor.sv -----
// ----------------------------------------------------------------------------
// rc4_with_xor_mask_decryptor
// Two-layer byte decryptor: repeating xor mask followed by an RC4 keystream,
// with the key schedule run from a 32-byte seed held in configuration.
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid/s_axis_tready    tdata: data_byte, tuser: kind
//   m_axis   out  m_axis_tvalid/m_axis_tready    tdata: plain_byte, tuser: no_mask
//   cfg      in   cfg_we (no wait, no read-back) cfg_index, cfg_wdata
//
// Cipher request: accept, read j, swap, keystream read, with three dependent
// reads on the one read port of the permutation table. Start request: accept,
// then key schedule of read i, read j, swap, write j for each table entry.
// Mask and unused requests are handled in idle. Reset leaves the identity
// table at once (valid bits). The result register lets the next request in
// while a result waits; a finished byte stalls only when that register is still full.
// ----------------------------------------------------------------------------
module rc4_with_xor_mask_decryptor #(
    parameter int SEED_BYTES = 32,
    parameter int MASK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] plain_byte
    output logic        m_axis_tuser,   // [0] no_mask
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    rxd_pkg::seed_t     seed_reg;
    rxd_pkg::tbl_req_t  tbl_req;
    rxd_pkg::mask_ctl_t mask_ctl;
    logic [7:0]         tbl_rd_data;
    logic [7:0]         mask_rd_data;
    logic               mask_empty;

    // seed registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rxd_pkg::REG_SEED0: seed_reg[0] <= cfg_wdata;
                rxd_pkg::REG_SEED1: seed_reg[1] <= cfg_wdata;
                rxd_pkg::REG_SEED2: seed_reg[2] <= cfg_wdata;
                rxd_pkg::REG_SEED3: seed_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    rxd_core #(
        .SEED_BYTES (SEED_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_kind       (s_axis_tuser),
        .s_data       (s_axis_tdata),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_data       (m_axis_tdata),
        .m_no_mask    (m_axis_tuser),
        .seed         (seed_reg),
        .tbl_req      (tbl_req),
        .tbl_rd_data  (tbl_rd_data),
        .mask_ctl     (mask_ctl),
        .mask_rd_data (mask_rd_data),
        .mask_empty   (mask_empty)
    );

    // permutation table
    rxd_sbox u_sbox (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // mask store
    rxd_mask #(
        .MASK_DEPTH (MASK_DEPTH)
    ) u_mask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mask_ctl),
        .push_data (s_axis_tdata),
        .rd_data   (mask_rd_data),
        .empty     (mask_empty)
    );

    // a start request always leads into the key schedule
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == rxd_pkg::KIND_START)
        |=> !s_axis_tready)
        else $error("input accepted right after a start request");

    // table writes only happen while a request is being worked on
    a_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en |-> !s_axis_tready)
        else $error("table written while idle");

    // mask grows only on an accepted mask request
    a_mask_push: assert property (@(posedge aclk) disable iff (!aresetn)
        mask_ctl.push |->
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == rxd_pkg::KIND_MASK))
        else $error("mask push without a mask request");

endmodule

// ----- rtl/rxd_sbox.sv -----
// ----------------------------------------------------------------------------
// rxd_sbox
// 256-entry permutation table: one write and one registered read per cycle,
// read-first. Per-entry valid bits make an unwritten entry read as its index.
// ----------------------------------------------------------------------------
module rxd_sbox (
    input  logic              aclk,
    input  logic              aresetn,
    input  rxd_pkg::tbl_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] tbl_mem [rxd_pkg::TBL_DEPTH];
    logic [rxd_pkg::TBL_DEPTH-1:0] valid_reg;
    logic [7:0] rd_raw_reg;
    logic       rd_hit_reg;
    logic [rxd_pkg::TBL_AW-1:0] rd_addr_reg;

    // valid bits: cleared at once by reset or a new key schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // storage with registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            tbl_mem[req.wr_addr] <= req.wr_data;
        end
        rd_raw_reg  <= tbl_mem[req.rd_addr];
        rd_hit_reg  <= valid_reg[req.rd_addr];
        rd_addr_reg <= req.rd_addr;
    end

    // entry never written since clear holds the identity value
    assign rd_data = rd_hit_reg ? rd_raw_reg : rd_addr_reg;

endmodule

// ----- rtl/rxd_mask.sv -----
// ----------------------------------------------------------------------------
// rxd_mask
// Repeating xor mask: byte store with fill length and a cycling read position.
// A pop reads the current byte (registered) and advances the position.
// ----------------------------------------------------------------------------
module rxd_mask #(
    parameter int MASK_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rxd_pkg::mask_ctl_t ctl,
    input  logic [7:0]         push_data,
    output logic [7:0]         rd_data,
    output logic               empty
);

    localparam int MASK_CAP = (MASK_DEPTH < 255) ? MASK_DEPTH : 255;
    localparam int LEN_W    = $clog2(MASK_CAP + 1);
    localparam int ADDR_W   = $clog2(MASK_DEPTH);

    logic [7:0]       mask_mem [MASK_DEPTH];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] pos_eff, pos_inc;
    logic [7:0]       rd_data_reg;
    logic             full;

    // fill and position bookkeeping
    always_comb begin
        full     = (len_reg == LEN_W'(MASK_CAP));
        empty    = (len_reg == '0);
        pos_eff  = (pos_reg >= len_reg) ? '0 : pos_reg;
        pos_inc  = pos_eff + LEN_W'(1);
        len_next = len_reg;
        pos_next = pos_reg;
        if (ctl.clear) begin
            len_next = '0;
            pos_next = '0;
        end else if (ctl.push && !full) begin
            len_next = len_reg + LEN_W'(1);
        end else if (ctl.pop && !empty) begin
            pos_next = (pos_inc >= len_reg) ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            pos_reg <= '0;
        end else begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    // byte store, appended at the fill length
    always_ff @(posedge aclk) begin
        if (ctl.push && !full) begin
            mask_mem[len_reg[ADDR_W-1:0]] <= push_data;
        end
        if (ctl.pop) begin
            rd_data_reg <= mask_mem[pos_eff[ADDR_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rxd_core.sv -----
// ----------------------------------------------------------------------------
// rxd_core
// Sequencer: runs the key schedule and the keystream step as read, read,
// swap phases on the permutation table, combines mask and keystream bytes
// and holds the result register.
// ----------------------------------------------------------------------------
module rxd_core #(
    parameter int SEED_BYTES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [7:0]          s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_data,
    output logic                m_no_mask,
    input  rxd_pkg::seed_t      seed,
    output rxd_pkg::tbl_req_t   tbl_req,
    input  logic [7:0]          tbl_rd_data,
    output rxd_pkg::mask_ctl_t  mask_ctl,
    input  logic [7:0]          mask_rd_data,
    input  logic                mask_empty
);

    localparam int SW = rxd_pkg::SEED_IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_RDI,
        ST_RDJ,
        ST_SWAP,
        ST_KS_WRJ,
        ST_OUT,
        ST_HOLD
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    i_reg, i_next;
    logic [7:0]    j_reg, j_next;
    logic [SW-1:0] seed_cnt_reg, seed_cnt_next;
    logic          ks_mode_reg, ks_mode_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_flag_reg, m_flag_next;
    logic [7:0]    si_reg, si_next;
    logic [7:0]    sj_reg, sj_next;
    logic [7:0]    t_reg, t_next;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    mbyte_reg, mbyte_next;
    logic          empty_reg, empty_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    seed_byte;
    logic [7:0]    ks;
    logic [7:0]    plain;
    logic          out_free;

    // seed byte for the current key schedule position
    assign seed_byte = seed[seed_cnt_reg[SW-1:3]][{seed_cnt_reg[2:0], 3'b000} +: 8];

    // keystream byte after the swap, forwarding the two fresh writes
    always_comb begin
        if (t_reg == j_reg) begin
            ks = si_reg;
        end else if (t_reg == i_reg) begin
            ks = sj_reg;
        end else begin
            ks = tbl_rd_data;
        end
        plain = data_reg ^ mbyte_reg ^ ks;
    end

    assign out_free = !m_valid_reg || m_ready;

    // phase sequencing
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        seed_cnt_next = seed_cnt_reg;
        ks_mode_next  = ks_mode_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_flag_next   = m_flag_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        data_next     = data_reg;
        mbyte_next    = mbyte_reg;
        empty_next    = empty_reg;
        pend_next     = pend_reg;
        tbl_req       = '0;
        mask_ctl      = '0;
        s_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        rxd_pkg::KIND_START: begin
                            tbl_req.clear  = 1'b1;
                            mask_ctl.clear = 1'b1;
                            i_next         = '0;
                            j_next         = '0;
                            seed_cnt_next  = '0;
                            ks_mode_next   = 1'b1;
                            state_next     = ST_KS_RDI;
                        end
                        rxd_pkg::KIND_MASK: begin
                            mask_ctl.push = 1'b1;
                        end
                        rxd_pkg::KIND_CIPHER: begin
                            mask_ctl.pop    = 1'b1;
                            empty_next      = mask_empty;
                            data_next       = s_data;
                            i_next          = i_reg + 8'd1;
                            tbl_req.rd_addr = i_reg + 8'd1;
                            ks_mode_next    = 1'b0;
                            state_next      = ST_RDJ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_KS_RDI: begin
                tbl_req.rd_addr = i_reg;
                state_next      = ST_RDJ;
            end
            ST_RDJ: begin
                si_next         = tbl_rd_data;
                j_next          = j_reg + tbl_rd_data + (ks_mode_reg ? seed_byte : 8'd0);
                tbl_req.rd_addr = j_next;
                mbyte_next      = empty_reg ? 8'd0 : mask_rd_data;
                state_next      = ST_SWAP;
            end
            ST_SWAP: begin
                sj_next         = tbl_rd_data;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = i_reg;
                tbl_req.wr_data = tbl_rd_data;
                t_next          = si_reg + tbl_rd_data;
                tbl_req.rd_addr = t_next;
                state_next      = ks_mode_reg ? ST_KS_WRJ : ST_OUT;
            end
            ST_KS_WRJ: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = j_reg;
                tbl_req.wr_data = si_reg;
                if (i_reg == 8'hFF) begin
                    i_next       = '0;
                    j_next       = '0;
                    ks_mode_next = 1'b0;
                    state_next   = ST_IDLE;
                end else begin
                    i_next        = i_reg + 8'd1;
                    seed_cnt_next = (seed_cnt_reg == SW'(SEED_BYTES - 1)) ? '0
                                                                         : seed_cnt_reg + SW'(1);
                    state_next    = ST_KS_RDI;
                end
            end
            ST_OUT: begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = j_reg;
                tbl_req.wr_data = si_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = plain;
                    m_flag_next  = empty_reg;
                    state_next   = ST_IDLE;
                end else begin
                    pend_next  = plain;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    m_flag_next  = empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, indices and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            seed_cnt_reg <= '0;
            ks_mode_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            seed_cnt_reg <= seed_cnt_next;
            ks_mode_reg  <= ks_mode_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_flag_reg <= m_flag_next;
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        t_reg      <= t_next;
        data_reg   <= data_next;
        mbyte_reg  <= mbyte_next;
        empty_reg  <= empty_next;
        pend_reg   <= pend_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign m_no_mask = m_flag_reg;

endmodule
